[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console cell writer: character
// classes, the item that travels from the front part to the back part, and
// queue sizing.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Character codes with a meaning of their own
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Cells written for one tab
  localparam int TAB_WIDTH = 4;
  localparam int TAB_STEP_W = $clog2(TAB_WIDTH);

  // Output field widths
  localparam int INDEX_W = 11;
  localparam int VALUE_W = 16;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Register map
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_ATTRIBUTE = 1'b0;
  localparam logic [7:0] ATTRIBUTE_RESET = 8'h70;

  typedef enum logic [1:0] {
    KIND_PRINT     = 2'd0,
    KIND_NEWLINE   = 2'd1,
    KIND_TAB       = 2'd2,
    KIND_BACKSPACE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
  } item_t;

  // Sort a character into its class
  function automatic item_t classify(input logic [7:0] code);
    item_t it;
    it.code = code;
    case (code)
      CH_NEWLINE:   it.kind = KIND_NEWLINE;
      CH_TAB:       it.kind = KIND_TAB;
      CH_BACKSPACE: it.kind = KIND_BACKSPACE;
      default:      it.kind = KIND_PRINT;
    endcase
    return it;
  endfunction

endpackage

[sv/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// Input stage: accepts characters, drops the zero code and registers each
// remaining character with its class for the queue.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       item_valid,
  input  logic       item_ready,
  output item_t      item
);

  logic  held;
  item_t held_item;
  logic  take;

  // Take a new item whenever the holding register is empty or drains now
  assign in_ready   = !held || item_ready;
  assign take       = in_valid && in_ready;
  assign item_valid = held;
  assign item       = held_item;

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= (char_code != CH_NUL);
    end else if (held && item_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item <= classify(char_code);
    end
  end

endmodule

[sv/tcw_queue.sv]
// ----------------------------------------------------------------------------
// tcw_queue
// Short first-in first-out queue between the front and back parts, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign wr_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

[sv/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// Execution stage: keeps the cursor and its column, carries out one cell
// write per cycle unless stalled (four for a tab), into an output register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS    = 80,
  parameter int CELL_COUNT = 2000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         attribute,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic [INDEX_W-1:0] cell_index,
  output logic [VALUE_W-1:0] cell_value,
  output logic               last_write,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int CW  = $clog2(CELL_COUNT + COLUMNS);
  localparam int CLW = $clog2(COLUMNS);

  logic [CW-1:0]         cursor;
  logic [CLW-1:0]        col;
  logic [TAB_STEP_W-1:0] tab_step;

  logic                  can_step;
  logic [CW-1:0]         pb_cur;
  logic [CLW-1:0]        pb_col;
  logic [CLW-1:0]        col_inc;
  logic [CLW-1:0]        col_dec;
  logic [CW-1:0]         cursor_next;
  logic [CLW-1:0]        col_next;
  logic                  emit;
  logic [CW-1:0]         emit_index;
  logic [7:0]            emit_char;
  logic                  emit_last;
  logic                  done;
  logic [CW+INDEX_W-1:0] index_wide;

  assign can_step   = item_valid && (!out_valid || out_ready);
  assign item_ready = can_step && done;

  // Pull a cursor at the end of the screen back one row, saturating at zero
  always_comb begin
    pb_cur = cursor;
    pb_col = col;
    if (cursor >= CW'(CELL_COUNT)) begin
      if (cursor >= CW'(COLUMNS)) begin
        pb_cur = cursor - CW'(COLUMNS);
      end else begin
        pb_cur = '0;
        pb_col = '0;
      end
    end
  end

  assign col_inc = (pb_col == CLW'(COLUMNS - 1)) ? '0 : pb_col + 1'b1;
  assign col_dec = (pb_col == '0) ? CLW'(COLUMNS - 1) : pb_col - 1'b1;

  // Work out one step of the current item
  always_comb begin
    cursor_next = pb_cur;
    col_next    = pb_col;
    emit        = 1'b0;
    emit_index  = pb_cur;
    emit_char   = CH_SPACE;
    emit_last   = 1'b1;
    done        = 1'b1;
    case (item.kind)
      KIND_NEWLINE: begin
        cursor_next = pb_cur + CW'(COLUMNS) - CW'(pb_col);
        col_next    = '0;
      end
      KIND_TAB: begin
        emit        = 1'b1;
        emit_last   = (tab_step == TAB_STEP_W'(TAB_WIDTH - 1));
        done        = emit_last;
        cursor_next = pb_cur + 1'b1;
        col_next    = col_inc;
      end
      KIND_BACKSPACE: begin
        if (pb_cur != '0) begin
          emit        = 1'b1;
          emit_index  = pb_cur - 1'b1;
          cursor_next = pb_cur - 1'b1;
          col_next    = col_dec;
        end
      end
      default: begin
        emit        = 1'b1;
        emit_char   = item.code;
        cursor_next = pb_cur + 1'b1;
        col_next    = col_inc;
      end
    endcase
  end

  assign index_wide = {{INDEX_W{1'b0}}, emit_index};

  // Advance cursor and step count, load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      col       <= '0;
      tab_step  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_step && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (can_step) begin
        cursor   <= cursor_next;
        col      <= col_next;
        tab_step <= done ? '0 : tab_step + 1'b1;
      end
    end
  end

  // Hold the write payload until it is taken
  always_ff @(posedge clk) begin
    if (can_step && emit) begin
      cell_index <= index_wide[INDEX_W-1:0];
      cell_value <= {attribute, emit_char};
      last_write <= emit_last;
    end
  end

endmodule

[sv/text_console_cell_writer.sv]
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Teletype over a text screen: turns characters into screen cell writes.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter on char_code with in_valid/in_ready; cell writes leave
//   on cell_index/cell_value/last_write with out_valid/out_ready. The colour
//   attribute is written over the APB port at byte address 0 (reset 0x70).
//   A newline gives no write, nor does a backspace at cell zero; code
//   zero is dropped. A tab gives four writes of a space; last_write marks
//   the final write of each character.
// Path and throughput:
//   The first write of a character passes the front register, the queue
//   and the output register. The back part issues one cell write per
//   cycle from its single output register while out_ready does not stall
//   it; a tab is carried out as four writes.
// Reset and stalls:
//   rst clears the cursor to cell zero, empties the queue and restores the
//   attribute. While out_ready is low the write is held, the back part stops
//   and the two-entry queue and front register fill before in_ready drops.
// ----------------------------------------------------------------------------
module text_console_cell_writer import tcw_pkg::*; #(
  parameter int COLUMNS    = 80,
  parameter int CELL_COUNT = 2000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_code,
  input  logic               in_valid,
  output logic               in_ready,
  output logic [INDEX_W-1:0] cell_index,
  output logic [VALUE_W-1:0] cell_value,
  output logic               last_write,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] attribute;
  logic       front_valid;
  logic       front_ready;
  item_t      front_item;
  logic       queue_valid;
  logic       queue_ready;
  item_t      queue_item;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_ATTRIBUTE) ? {24'b0, attribute} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTRIBUTE_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1:2] == REG_ATTRIBUTE)) begin
      attribute <= pwdata[7:0];
    end
  end

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_item  (queue_item)
  );

  tcw_back #(
    .COLUMNS    (COLUMNS),
    .CELL_COUNT (CELL_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .attribute  (attribute),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .last_write (last_write),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

[sv/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; #(
  parameter int CELL_COUNT = 2000
) (
  input logic               clk,
  input logic               rst,
  input logic [INDEX_W-1:0] cell_index,
  input logic [VALUE_W-1:0] cell_value,
  input logic               last_write,
  input logic               out_valid,
  input logic               out_ready,
  input logic               pready
);

  // Drop any write on reset
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("write shown right after reset");

  // Hold a stalled write
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_index)
      && $stable(cell_value) && $stable(last_write))
    else $error("stalled write changed");

  // Keep writes on the screen
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CELL_COUNT > (1 << INDEX_W)) || (cell_index < CELL_COUNT))
    else $error("cell index beyond the screen");

  // Only tab spaces may be followed by more writes of the same item
  a_mid_is_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_write |-> cell_value[7:0] == CH_SPACE)
    else $error("non-final write is not a space");

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind text_console_cell_writer tcw_checker #(
  .CELL_COUNT (CELL_COUNT)
) u_tcw_checker (
  .clk        (clk),
  .rst        (rst),
  .cell_index (cell_index),
  .cell_value (cell_value),
  .last_write (last_write),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pready     (pready)
);
